FILE: hdl/worst_fit_block_allocator_defines.svh
// Shared assertion macros for the block allocator checkers.
`ifndef WORST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WFBA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define WFBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/wfba_pkg.sv
package wfba_pkg;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_ALLOC = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_LOADED    = 2'd0,
      ST_ALLOCATED = 2'd1,
      ST_NO_FIT    = 2'd2
   } status_type;

   localparam int             CSR_ADDR_W       = 3;
   localparam int             NUM_BLOCKS_W     = 7;
   localparam logic [6:0]     NUM_BLOCKS_RESET = 7'd64;
   localparam int             BLOCK_INDEX_W    = 6;
   localparam int             REQ_SIZE_W       = 16;

endpackage

FILE: hdl/worst_fit_block_allocator.sv
// Worst-fit block allocator. A load (req_type 0) writes one block's free size
// and its transfer shows on rsp_* in the cycle right after start is taken;
// busy stays low, so loads can go back to back, one per cycle. An allocation
// request (req_type 1) searches the first num_blocks blocks for the largest
// free size (lowest index on a tie) and carves the request from it if it
// fits. The search runs through a chain of MAX_BLOCKS cells, one block per
// cell and one cell per cycle, so a request holds busy while it scans and
// finishes, and the next item is taken once busy drops; its result shows
// in the cycle busy drops. Every result is a single-cycle rsp_valid pulse
// that the receiver cannot stall: capture it when it shows.
// Write num_blocks only while busy is low and no result is pending.
module worst_fit_block_allocator #(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // item channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [wfba_pkg::BLOCK_INDEX_W-1:0] req_block_index,
   input  logic [wfba_pkg::REQ_SIZE_W-1:0]    req_size,
   // result channel
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [wfba_pkg::BLOCK_INDEX_W-1:0] rsp_chosen_block,
   output logic [wfba_pkg::REQ_SIZE_W-1:0]    rsp_size_before,
   output logic [wfba_pkg::REQ_SIZE_W-1:0]    rsp_leftover,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [wfba_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } fsm_type;

   // Controller state
   fsm_type              state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;

   // Result registers
   logic                               rsp_valid_ff, rsp_valid_in;
   wfba_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [wfba_pkg::BLOCK_INDEX_W-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic [wfba_pkg::REQ_SIZE_W-1:0]    rsp_before_ff, rsp_before_in;
   logic [wfba_pkg::REQ_SIZE_W-1:0]    rsp_left_ff, rsp_left_in;

   // Configuration
   logic [wfba_pkg::NUM_BLOCKS_W-1:0]  num_blocks_ff, num_blocks_in;
   logic                               csr_wr;

   // Scan chain taps: tap 0 feeds cell 0, tap MAX_BLOCKS is the last cell out.
   logic                 scan_found [MAX_BLOCKS+1];
   logic [IDX_W-1:0]     scan_idx   [MAX_BLOCKS+1];
   logic [SIZE_BITS-1:0] scan_size  [MAX_BLOCKS+1];

   logic                 accept;
   logic                 load_accept;
   logic                 fit;
   logic                 grant_wr;
   logic [SIZE_BITS-1:0] leftover_calc;
   logic [SIZE_BITS-1:0] wr_data;
   logic [MAX_BLOCKS-1:0] cell_wr;
   logic [MAX_BLOCKS-1:0] cell_active;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign load_accept = accept && (req_type == wfba_pkg::REQ_LOAD);

   // Feed an empty candidate into the head of the chain every cycle.
   assign scan_found[0] = 1'b0;
   assign scan_idx[0]   = '0;
   assign scan_size[0]  = '0;

   // Largest block sits at the chain tail once the scan has run its length.
   assign leftover_calc = scan_size[MAX_BLOCKS] - size_ff;
   assign fit           = scan_found[MAX_BLOCKS] && (size_ff <= scan_size[MAX_BLOCKS]);
   assign grant_wr      = (state_ff == S_FINISH) && fit;
   assign wr_data       = (state_ff == S_FINISH) ? leftover_calc : SIZE_BITS'(req_size);

   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      // Cells past num_blocks pass the candidate through untouched.
      assign cell_active[k] = (32'(num_blocks_ff) > 32'(k));
      assign cell_wr[k] = (load_accept && (32'(req_block_index) == 32'(k)))
                        || (grant_wr && (scan_idx[MAX_BLOCKS] == IDX_W'(k)));

      wfba_cell #(
         .SIZE_BITS (SIZE_BITS),
         .IDX_W     (IDX_W),
         .CELL_ID   (k)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .active         (cell_active[k]),
         .wr_en          (cell_wr[k]),
         .wr_data        (wr_data),
         .scan_found_in  (scan_found[k]),
         .scan_idx_in    (scan_idx[k]),
         .scan_size_in   (scan_size[k]),
         .scan_found_out (scan_found[k+1]),
         .scan_idx_out   (scan_idx[k+1]),
         .scan_size_out  (scan_size[k+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      size_in       = size_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_before_in = rsp_before_ff;
      rsp_left_in   = rsp_left_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_type == wfba_pkg::REQ_LOAD) begin
                  // Load completes at accept; report it next cycle.
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = wfba_pkg::ST_LOADED;
                  rsp_chosen_in = '0;
                  rsp_before_in = '0;
                  rsp_left_in   = '0;
               end else begin
                  state_in = S_SCAN;
                  cnt_in   = '0;
                  size_in  = SIZE_BITS'(req_size);
               end
            end
         end
         S_SCAN: begin
            // Wait for a fresh candidate to travel the whole chain.
            if (cnt_ff == IDX_W'(MAX_BLOCKS - 1)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (fit) begin
               rsp_status_in = wfba_pkg::ST_ALLOCATED;
               rsp_chosen_in = wfba_pkg::BLOCK_INDEX_W'(scan_idx[MAX_BLOCKS]);
               rsp_before_in = wfba_pkg::REQ_SIZE_W'(scan_size[MAX_BLOCKS]);
               rsp_left_in   = wfba_pkg::REQ_SIZE_W'(leftover_calc);
            end else begin
               rsp_status_in = wfba_pkg::ST_NO_FIT;
               rsp_chosen_in = '0;
               rsp_before_in = '0;
               rsp_left_in   = '0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Register port: num_blocks decodes on the word address, low bits ignored.
   assign csr_wr        = psel && penable && pwrite && pready
                        && (paddr[wfba_pkg::CSR_ADDR_W-1] == 1'b0);
   assign num_blocks_in = csr_wr ? pwdata[wfba_pkg::NUM_BLOCKS_W-1:0] : num_blocks_ff;
   assign pready        = 1'b1;
   assign prdata        = (paddr[wfba_pkg::CSR_ADDR_W-1] == 1'b0)
                        ? {{(32 - wfba_pkg::NUM_BLOCKS_W){1'b0}}, num_blocks_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         num_blocks_ff <= wfba_pkg::NUM_BLOCKS_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         num_blocks_ff <= num_blocks_in;
      end
      cnt_ff        <= cnt_in;
      size_ff       <= size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_before_ff <= rsp_before_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_size_before  = rsp_before_ff;
   assign rsp_leftover     = rsp_left_ff;

endmodule

FILE: hdl/wfba_cell.sv
module wfba_cell #(
   parameter int SIZE_BITS = 16,
   parameter int IDX_W     = 6,
   parameter int CELL_ID   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 active,
   input  logic                 wr_en,
   input  logic [SIZE_BITS-1:0] wr_data,
   input  logic                 scan_found_in,
   input  logic [IDX_W-1:0]     scan_idx_in,
   input  logic [SIZE_BITS-1:0] scan_size_in,
   output logic                 scan_found_out,
   output logic [IDX_W-1:0]     scan_idx_out,
   output logic [SIZE_BITS-1:0] scan_size_out
);

   logic [SIZE_BITS-1:0] entry_ff, entry_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 take;

   // Strictly larger wins, so the lowest index keeps a tie.
   assign take = active && (!scan_found_in || (entry_ff > scan_size_in));

   always_comb begin
      entry_in = wr_en ? wr_data : entry_ff;
      found_in = scan_found_in || active;
      idx_in   = take ? IDX_W'(CELL_ID) : scan_idx_in;
      size_in  = take ? entry_ff : scan_size_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         found_ff <= found_in;
      end
      idx_ff  <= idx_in;
      size_ff <= size_in;
   end

   assign scan_found_out = found_ff;
   assign scan_idx_out   = idx_ff;
   assign scan_size_out  = size_ff;

endmodule

FILE: hdl/wfba_checker.sv
`include "worst_fit_block_allocator_defines.svh"

module wfba_assertions (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               req_type,
   input logic                               rsp_valid,
   input logic [1:0]                         rsp_status,
   input logic [wfba_pkg::BLOCK_INDEX_W-1:0] rsp_chosen_block,
   input logic [wfba_pkg::REQ_SIZE_W-1:0]    rsp_size_before,
   input logic [wfba_pkg::REQ_SIZE_W-1:0]    rsp_leftover
);

   logic load_xfer;
   logic alloc_xfer;
   logic rsp_blank;
   logic load_done;
   logic busy_quiet;
   logic rsp_unused;
   logic search_rsp;

   assign load_xfer  = start && !busy && (req_type == wfba_pkg::REQ_LOAD);
   assign alloc_xfer = start && !busy && (req_type == wfba_pkg::REQ_ALLOC);
   assign rsp_blank  = (rsp_chosen_block == '0) && (rsp_size_before == '0)
                     && (rsp_leftover == '0);
   assign load_done  = rsp_valid && (rsp_status == wfba_pkg::ST_LOADED);
   assign busy_quiet = busy && !rsp_valid;
   assign rsp_unused = rsp_valid && (rsp_status != wfba_pkg::ST_ALLOCATED);
   assign search_rsp = rsp_valid && (rsp_status != wfba_pkg::ST_LOADED);

   `WFBA_ASSERT_NEXT(a_load_reports, load_xfer, load_done, "load not reported next cycle")
   `WFBA_ASSERT_NEXT(a_alloc_busy, alloc_xfer, busy_quiet, "request did not raise busy")
   `WFBA_ASSERT_NOW(a_blank_fields, rsp_unused, rsp_blank, "non-granted result carries data")
   `WFBA_ASSERT_NOW(a_alloc_end, search_rsp, $fell(busy), "request result not at busy release")

endmodule

bind worst_fit_block_allocator wfba_assertions u_wfba_assertions (.*);

FILE: tb/wfba_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and register channels of the allocator, keeps a
// shadow of the free-size table and compares every result transfer in order.
module wfba_checker #(
   parameter logic [wfba_pkg::CSR_ADDR_W-1:0] NUM_BLOCKS_ADDR = '0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_type,
   input  logic [wfba_pkg::BLOCK_INDEX_W-1:0] req_block_index,
   input  logic [wfba_pkg::REQ_SIZE_W-1:0]    req_size,
   input  logic                               rsp_valid,
   input  logic [1:0]                         rsp_status,
   input  logic [wfba_pkg::BLOCK_INDEX_W-1:0] rsp_chosen_block,
   input  logic [wfba_pkg::REQ_SIZE_W-1:0]    rsp_size_before,
   input  logic [wfba_pkg::REQ_SIZE_W-1:0]    rsp_leftover,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [wfba_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   input  logic [31:0]                        prdata,
   input  logic                               pready,
   output int                                 fail_count,
   output int                                 pending
);
   import wfba_pkg::*;

   localparam int TABLE_DEPTH = 64;

   typedef struct packed {
      status_type                status;
      logic [BLOCK_INDEX_W-1:0]  block;
      logic [REQ_SIZE_W-1:0]     size_prev;
      logic [REQ_SIZE_W-1:0]     leftover;
   } alloc_result_type;

   logic [REQ_SIZE_W-1:0]   free_size [TABLE_DEPTH];
   logic [NUM_BLOCKS_W-1:0] blocks_in_use;
   alloc_result_type        results_due [$];

   task automatic report_mismatch(string field, longint got, longint want);
      $display("checker: %s got %0h want %0h at %0t", field, got, want, $time);
      fail_count++;
   endtask

   // Apply one item to the shadow table and return the result it owes.
   function automatic alloc_result_type apply_item(req_kind_type kind,
                                                   logic [BLOCK_INDEX_W-1:0] idx,
                                                   logic [REQ_SIZE_W-1:0] size);
      alloc_result_type      res;
      int                    limit;
      int                    best;
      logic [REQ_SIZE_W-1:0] best_size;
      res = '{status: ST_LOADED, block: '0, size_prev: '0, leftover: '0};
      if (kind == REQ_LOAD) begin
         free_size[idx] = size;
         return res;
      end
      limit = (blocks_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_in_use);
      best = 0;
      best_size = '0;
      for (int k = 0; k < limit; k++) begin
         if (k == 0 || free_size[k] > best_size) begin
            best = k;
            best_size = free_size[k];
         end
      end
      if (limit > 0 && size <= best_size) begin
         free_size[best] = best_size - size;
         res.status = ST_ALLOCATED;
         res.block = best[BLOCK_INDEX_W-1:0];
         res.size_prev = best_size;
         res.leftover = best_size - size;
      end else begin
         res.status = ST_NO_FIT;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         foreach (free_size[i]) free_size[i] = '0;
         blocks_in_use = NUM_BLOCKS_RESET;
         results_due.delete();
         fail_count = 0;
      end else begin
         // A result is never due in the same cycle its item is taken.
         if (rsp_valid) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result, status", rsp_status, 0);
            end else begin
               want = results_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_chosen_block !== want.block)
                  report_mismatch("chosen_block", rsp_chosen_block, want.block);
               if (rsp_size_before !== want.size_prev)
                  report_mismatch("size_before", rsp_size_before, want.size_prev);
               if (rsp_leftover !== want.leftover)
                  report_mismatch("leftover", rsp_leftover, want.leftover);
            end
         end
         if (start && !busy)
            results_due.push_back(apply_item(req_kind_type'(req_type),
                                             req_block_index, req_size));
         if (psel && penable && pready && paddr == NUM_BLOCKS_ADDR) begin
            if (pwrite)
               blocks_in_use = pwdata[NUM_BLOCKS_W-1:0];
            else if (prdata !== {{(32-NUM_BLOCKS_W){1'b0}}, blocks_in_use})
               report_mismatch("num_blocks readback", prdata, blocks_in_use);
         end
      end
      pending = results_due.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the worst-fit allocator. The checker beside the
// block does all prediction; this module only drives transfers and decides.
module tb_top;
   import wfba_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] NUM_BLOCKS_ADDR = '0;
   localparam int TABLE_DEPTH    = 64;
   localparam int STALL_LIMIT    = 4000;  // cycles with no transfer at all
   localparam int PHASE_ITEMS    = 60;
   localparam int RANDOM_PHASES  = 8;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_type = REQ_LOAD;
   logic [BLOCK_INDEX_W-1:0] req_block_index = '0;
   logic [REQ_SIZE_W-1:0]    req_size = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic [BLOCK_INDEX_W-1:0] rsp_chosen_block;
   logic [REQ_SIZE_W-1:0]    rsp_size_before;
   logic [REQ_SIZE_W-1:0]    rsp_leftover;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;
   int                       fail_count;
   int                       pending;
   int                       stall_cycles = 0;

   always #1 clock = ~clock;

   worst_fit_block_allocator u_top (
      .clock, .reset,
      .start, .busy, .req_type, .req_block_index, .req_size,
      .rsp_valid, .rsp_status, .rsp_chosen_block, .rsp_size_before, .rsp_leftover,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   wfba_checker #(.NUM_BLOCKS_ADDR(NUM_BLOCKS_ADDR)) u_checker (
      .clock, .reset,
      .start, .busy, .req_type, .req_block_index, .req_size,
      .rsp_valid, .rsp_status, .rsp_chosen_block, .rsp_size_before, .rsp_leftover,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .fail_count, .pending
   );

   // Watchdog: any item, result or register transfer counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Hold the item on the ports until the block takes it. busy is sampled at
   // the falling edge, so it is the value the next rising edge will see.
   task automatic push_item(req_kind_type kind, logic [BLOCK_INDEX_W-1:0] idx,
                            logic [REQ_SIZE_W-1:0] size);
      bit taken;
      req_type        <= kind;
      req_block_index <= idx;
      req_size        <= size;
      start           <= 1'b1;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // Drop start for a while; a zero gap keeps start high into the next item.
   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Mostly back to back or short gaps, now and then a long one that spans
   // a good part of a search.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 17) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // Stop sending and wait until every result owed has come back.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_access(bit is_write, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= NUM_BLOCKS_ADDR;
      pwdata  <= is_write ? data : 32'h0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Change the search width only with the block idle, then read it back.
   task automatic set_num_blocks(logic [NUM_BLOCKS_W-1:0] nb);
      drain();
      csr_access(1'b1, 32'(nb));
      csr_access(1'b0, 32'h0);
   endtask

   function automatic logic [REQ_SIZE_W-1:0] pick_load_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return REQ_SIZE_W'($urandom_range(0, 65535));
         default: return REQ_SIZE_W'($urandom_range(1, 3000));
      endcase
   endfunction

   // Request sizes lean small so most of them get carved, with full-range
   // and extreme sizes mixed in to reach the no-fit path.
   function automatic logic [REQ_SIZE_W-1:0] pick_request_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return REQ_SIZE_W'($urandom_range(0, 65535));
         default: return REQ_SIZE_W'($urandom_range(1, 1500));
      endcase
   endfunction

   // Loads fill the searched part of the table most of the time, so the
   // requests that follow compete over blocks that actually hold space.
   task automatic run_phase(int count, logic [NUM_BLOCKS_W-1:0] nb, bit quiet);
      int                       in_use;
      logic [BLOCK_INDEX_W-1:0] idx;
      in_use = (nb > TABLE_DEPTH) ? TABLE_DEPTH : int'(nb);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 50) begin
            if (in_use > 0 && $urandom_range(0, 3) != 0)
               idx = BLOCK_INDEX_W'($urandom_range(0, in_use - 1));
            else
               idx = BLOCK_INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
            push_item(REQ_LOAD, idx, pick_load_size());
         end else begin
            push_item(REQ_ALLOC, BLOCK_INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                      pick_request_size());
         end
         idle_gap(quiet ? 0 : pick_gap());
      end
   endtask

   initial begin
      logic [NUM_BLOCKS_W-1:0] nb_plan [RANDOM_PHASES];
      nb_plan = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd32, 7'd0, 7'd17, 7'd64};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of the search width must read back.
      csr_access(1'b0, 32'h0);

      // Empty table: a zero request fits block 0 exactly, anything else fails.
      push_item(REQ_ALLOC, '0, '0);
      idle_gap(pick_gap());
      push_item(REQ_ALLOC, '1, 16'd1);
      idle_gap(pick_gap());
      // Largest sizes at both ends of the table; the tie goes to block 0.
      push_item(REQ_LOAD, 6'd0, '1);
      push_item(REQ_LOAD, 6'd63, '1);
      push_item(REQ_LOAD, 6'd5, 16'd100);
      idle_gap(pick_gap());
      push_item(REQ_ALLOC, '0, '1);    // exact fit in block 0
      push_item(REQ_ALLOC, '0, '1);    // exact fit in block 63
      push_item(REQ_ALLOC, '0, '0);    // zero request leaves block 5 alone
      push_item(REQ_ALLOC, '0, 16'd101);
      push_item(REQ_ALLOC, '0, 16'd100);
      idle_gap(pick_gap());
      push_item(REQ_LOAD, 6'd63, 16'h5555);
      push_item(REQ_LOAD, 6'd0, 16'hAAAA);
      push_item(REQ_ALLOC, 6'd63, 16'h1234);
      push_item(REQ_ALLOC, '0, '1);

      // One-entry search: only block 0 is looked at.
      set_num_blocks(7'd1);
      push_item(REQ_LOAD, 6'd1, '1);
      push_item(REQ_ALLOC, '0, 16'd10);
      push_item(REQ_ALLOC, '0, 16'hFFF0);

      // Zero-entry search: even a zero request has nowhere to go.
      set_num_blocks(7'd0);
      push_item(REQ_ALLOC, '0, '0);

      // Width above the table saturates to the full table.
      set_num_blocks(7'd127);
      push_item(REQ_LOAD, 6'd62, 16'hFFFE);
      push_item(REQ_ALLOC, '0, 16'd2);
      push_item(REQ_ALLOC, '0, '0);

      // Random phases, each under its own search width. Every third one runs
      // with no idling at all on the item side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 6) nb_plan[p] = NUM_BLOCKS_W'($urandom_range(3, 63));
         set_num_blocks(nb_plan[p]);
         run_phase(PHASE_ITEMS, nb_plan[p], (p % 3) == 1);
      end

      drain();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
